@@ src/akm_pkg.sv @@
// Shared types, constants and the key character table of the multi-tap keypad entry unit.
package akm_pkg;

    // Default number of entries in the text ring.
    localparam int AKM_RING_DEPTH = 8;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int WINDOW_W = 8;
    localparam int TOL_W    = 12;
    localparam int SUM_W    = 20;
    localparam int CHAR_W   = 7;
    localparam int CFG_W    = 12;
    localparam int KEY_W    = 4;
    localparam int TAP_W    = 2;

    // The divider produces one quotient bit per step over the whole sum.
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register indexes of the configuration port.
    localparam logic REG_WINDOW_LENGTH       = 1'b0;
    localparam logic REG_STABILITY_TOLERANCE = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 8'd80;
    localparam logic [TOL_W-1:0]    TOLERANCE_RESET = 12'd100;

    // Key code that means no key has been seen yet.
    localparam logic [KEY_W:0] NO_KEY = 5'd16;

    // Special characters.
    localparam logic [CHAR_W-1:0] CH_SKIP  = 7'h5F;
    localparam logic [CHAR_W-1:0] CH_FLUSH = 7'h26;

    // Destinations of a result.
    localparam logic DEST_DISPLAY = 1'b0;
    localparam logic DEST_UART    = 1'b1;

    // Four characters for each of the sixteen keys, indexed by {key, tap}.
    localparam logic [CHAR_W-1:0] KEY_CHARS [64] = '{
        7'h31, 7'h41, 7'h42, 7'h43,   // 1 A B C
        7'h32, 7'h44, 7'h45, 7'h46,   // 2 D E F
        7'h33, 7'h47, 7'h48, 7'h49,   // 3 G H I
        7'h21, 7'h32, 7'h33, 7'h34,   // ! 2 3 4
        7'h34, 7'h4A, 7'h4B, 7'h4C,   // 4 J K L
        7'h35, 7'h4D, 7'h4E, 7'h4F,   // 5 M N O
        7'h36, 7'h50, 7'h51, 7'h52,   // 6 P Q R
        7'h2C, 7'h53, 7'h54, 7'h55,   // , S T U
        7'h37, 7'h56, 7'h57, 7'h58,   // 7 V W X
        7'h38, 7'h59, 7'h5A, 7'h5F,   // 8 Y Z _
        7'h39, 7'h5F, 7'h5F, 7'h5F,   // 9 _ _ _
        7'h2E, 7'h5F, 7'h5F, 7'h5F,   // . _ _ _
        7'h2B, 7'h2D, 7'h2A, 7'h2F,   // + - * /
        7'h26, 7'h26, 7'h26, 7'h26,   // & & & &
        7'h30, 7'h20, 7'h5F, 7'h5F,   // 0 space _ _
        7'h3C, 7'h5F, 7'h5F, 7'h5F    // < _ _ _
    };

    function automatic logic [CHAR_W-1:0] akm_key_char(input logic [KEY_W-1:0] key,
                                                      input logic [TAP_W-1:0] tap);
        return KEY_CHARS[{key, tap}];
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // input transaction accepted this cycle
        logic div_step;    // one restoring division step
        logic commit_key;  // accepted window: update key, tap and character
        logic emit;        // show character, store it in the ring
        logic flush_read;  // read ring entry at the flush index
        logic flush_out;   // send the read entry on the UART
    } akm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_close;  // the next sample closes the window
        logic div_last;      // last division step
        logic accept;        // window is stable
        logic is_skip;       // selected character emits nothing
        logic is_flush;      // selected character flushes the ring
        logic fill_zero;     // text ring is empty
        logic flush_last;    // flush index is the last filled entry
        logic out_free;      // output register can take a result
    } akm_status_t;

endpackage

@@ src/adc_keypad_multitap_entry_unit.sv @@
// Top level of the resistor-ladder keypad multi-tap text entry unit.
//
//   Channel   Handshake            Payload                                  Direction
//   input     in_valid/in_ready    sample[11:0]                             into block
//   output    out_valid/out_ready  destination, character[6:0], last_of_run out of block
//   config    cfg_we               cfg_index, cfg_data[11:0]                into block
//
// A sample that does not close the averaging window leaves the controller ready for
// the next sample. A sample that closes it runs the restoring divider (one quotient
// bit per cycle over the 20-bit sum) and a decision state, then an emit state for a
// displayed character, or a registered ring read and an output state per flushed byte.
// Reset is asynchronous and active low; it restores the configuration defaults
// and clears counters, the key history and the ring fill count.
// A stalled output only holds the controller when it has a new result to load.
//
// Each accepted sample is added into a 20-bit window sum. When the sample count
// reaches the window length, the sum is divided by the window length (256 for a
// zero register) and the average is checked against the last sample and the
// stability tolerance. A stable window selects a key (average bits 11:8). Pressing
// the same key again steps the tap index modulo four; a new key restarts it. The
// character table gives the character: an underscore produces no transaction, an
// ampersand sends every buffered character on the UART in order, and anything
// else is shown on the display and appended to the text ring.
module adc_keypad_multitap_entry_unit import akm_pkg::*; #(
    parameter int RING_DEPTH = AKM_RING_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                destination,
    output logic [CHAR_W-1:0]   character,
    output logic                last_of_run
);

    akm_cmd_t    cmd;
    akm_status_t status;

    // Sequencing of the window decision, display write and ring flush.
    akm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Window sum, divider, key and tap state, text ring and output register.
    akm_dp #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .destination(destination),
        .character  (character),
        .last_of_run(last_of_run)
    );

    // Only flushed bytes can be followed by more results of the same sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> (destination == DEST_UART))
        else $error("non-final result was not a UART byte");

    // Skip and flush characters are never shown on the display.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && destination == DEST_DISPLAY) |->
            (character != CH_SKIP && character != CH_FLUSH))
        else $error("control character sent to the display");

    // No new sample transaction is taken while the divider is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ready)
        else $error("input ready during division");

endmodule

@@ src/akm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module akm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/akm_ctrl.sv @@
// Controller state machine of the multi-tap keypad entry unit.
module akm_ctrl import akm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  akm_status_t status,
    output akm_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DIV       = 6'b000010,
        S_DECIDE    = 6'b000100,
        S_EMIT      = 6'b001000,
        S_FLUSH_RD  = 6'b010000,
        S_FLUSH_OUT = 6'b100000
    } akm_state_t;

    akm_state_t state_reg;
    akm_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && status.window_close)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.commit_key = status.accept;
                priority if (!status.accept || status.is_skip)
                begin
                    state_next = S_IDLE;
                end
                else if (status.is_flush)
                begin
                    state_next = status.fill_zero ? S_IDLE : S_FLUSH_RD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH_RD:
            begin
                cmd.flush_read = 1'b1;
                state_next     = S_FLUSH_OUT;
            end
            S_FLUSH_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.flush_out = 1'b1;
                    state_next    = status.flush_last ? S_IDLE : S_FLUSH_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/akm_dp.sv @@
// Datapath of the multi-tap keypad entry unit: window sum, divider, key logic, ring and output.
module akm_dp import akm_pkg::*; #(
    parameter int RING_DEPTH = AKM_RING_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [SAMPLE_W-1:0] sample,
    input  akm_cmd_t            cmd,
    output akm_status_t         status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                destination,
    output logic [CHAR_W-1:0]   character,
    output logic                last_of_run
);

    localparam int FILL_W = $clog2(RING_DEPTH);

    logic [WINDOW_W-1:0]  window_reg,   window_next;
    logic [TOL_W-1:0]     tol_reg,      tol_next;
    logic [WINDOW_W-1:0]  count_reg,    count_next;
    logic [SUM_W-1:0]     sum_reg,      sum_next;
    logic [SAMPLE_W-1:0]  sample_reg,   sample_next;
    logic [KEY_W:0]       prev_key_reg, prev_key_next;
    logic [TAP_W-1:0]     tap_reg,      tap_next;
    logic [FILL_W-1:0]    fill_reg,     fill_next;
    logic [FILL_W-1:0]    idx_reg,      idx_next;
    logic [SUM_W-1:0]     div_q_reg,    div_q_next;
    logic [WINDOW_W:0]    div_rem_reg,  div_rem_next;
    logic [WINDOW_W:0]    divisor_reg,  divisor_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,  div_cnt_next;
    logic [CHAR_W-1:0]    char_reg,     char_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_dest_reg,  out_dest_next;
    logic [CHAR_W-1:0]    out_char_reg,  out_char_next;
    logic                 out_last_reg,  out_last_next;

    logic [WINDOW_W-1:0]  count_inc;
    logic [SUM_W-1:0]     sum_add;
    logic [WINDOW_W+1:0]  trial;
    logic [WINDOW_W+1:0]  trial_diff;
    logic                 trial_ge;
    logic [SUM_W-1:0]     gap;
    logic [KEY_W-1:0]     key;
    logic [TAP_W-1:0]     tap_new;
    logic [CHAR_W-1:0]    char_new;
    logic                 fill_last;
    logic [CHAR_W-1:0]    ring_rdata;

    akm_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (cmd.emit),
        .waddr(fill_reg),
        .wdata(char_reg),
        .re   (cmd.flush_read),
        .raddr(idx_reg),
        .rdata(ring_rdata)
    );

    always_comb
    begin
        count_inc  = count_reg + WINDOW_W'(1);
        sum_add    = sum_reg + SUM_W'(sample);
        trial      = {div_rem_reg, div_q_reg[SUM_W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        trial_ge   = trial >= {1'b0, divisor_reg};
        gap        = div_q_reg - SUM_W'(sample_reg);
        key        = div_q_reg[KEY_W+7:8];
        tap_new    = ({1'b0, key} == prev_key_reg) ? tap_reg + TAP_W'(1) : '0;
        char_new   = akm_key_char(key, tap_new);
        fill_last  = fill_reg == FILL_W'(RING_DEPTH - 1);

        status.window_close = count_inc == window_reg;
        status.div_last     = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
        status.accept       = (div_q_reg >= SUM_W'(sample_reg)) && (gap < SUM_W'(tol_reg));
        status.is_skip      = char_new == CH_SKIP;
        status.is_flush     = char_new == CH_FLUSH;
        status.fill_zero    = fill_reg == '0;
        status.flush_last   = idx_reg == fill_reg - FILL_W'(1);
        status.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        window_next    = window_reg;
        tol_next       = tol_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        prev_key_next  = prev_key_reg;
        tap_next       = tap_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        div_q_next     = div_q_reg;
        div_rem_next   = div_rem_reg;
        divisor_next   = divisor_reg;
        div_cnt_next   = div_cnt_reg;
        char_next      = char_reg;
        out_valid_next = out_valid_reg;
        out_dest_next  = out_dest_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:       window_next = cfg_data[WINDOW_W-1:0];
                REG_STABILITY_TOLERANCE: tol_next    = cfg_data[TOL_W-1:0];
                default:                 ;
            endcase
        end

        if (cmd.take)
        begin
            sample_next = sample;
            if (status.window_close)
            begin
                // A zero window length wraps the counter, so it divides by 256.
                count_next   = '0;
                sum_next     = '0;
                div_q_next   = sum_add;
                div_rem_next = '0;
                div_cnt_next = '0;
                divisor_next = (window_reg == '0) ? {1'b1, {WINDOW_W{1'b0}}}
                                                  : {1'b0, window_reg};
            end
            else
            begin
                count_next = count_inc;
                sum_next   = sum_add;
            end
        end

        if (cmd.div_step)
        begin
            div_q_next   = {div_q_reg[SUM_W-2:0], trial_ge};
            div_rem_next = trial_ge ? trial_diff[WINDOW_W:0] : trial[WINDOW_W:0];
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.commit_key)
        begin
            prev_key_next = {1'b0, key};
            tap_next      = tap_new;
            char_next     = char_new;
            idx_next      = '0;
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            fill_next      = fill_last ? '0 : fill_reg + FILL_W'(1);
            out_valid_next = 1'b1;
            out_dest_next  = DEST_DISPLAY;
            out_char_next  = char_reg;
            out_last_next  = 1'b1;
        end

        if (cmd.flush_out)
        begin
            idx_next       = idx_reg + FILL_W'(1);
            out_valid_next = 1'b1;
            out_dest_next  = DEST_UART;
            out_char_next  = ring_rdata;
            out_last_next  = status.flush_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            tol_reg       <= TOLERANCE_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            prev_key_reg  <= NO_KEY;
            tap_reg       <= '0;
            fill_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            tol_reg       <= tol_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            prev_key_reg  <= prev_key_next;
            tap_reg       <= tap_next;
            fill_reg      <= fill_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        idx_reg      <= idx_next;
        div_q_reg    <= div_q_next;
        div_rem_reg  <= div_rem_next;
        divisor_reg  <= divisor_next;
        char_reg     <= char_next;
        out_dest_reg <= out_dest_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign destination = out_dest_reg;
    assign character   = out_char_reg;
    assign last_of_run = out_last_reg;

endmodule
